// ----- design/rrfb_pkg.sv -----
`default_nettype none
package rrfb_pkg;

  // Pipeline layout: geometry setup, square-root digits, span test and blend.
  localparam int GEOM_STAGES  = 4;
  localparam int SQRT_STAGES  = 6;
  localparam int BLEND_STAGES = 2;
  localparam int STAGES       = GEOM_STAGES + SQRT_STAGES + BLEND_STAGES;

  localparam int POS_W      = 15;
  localparam int ROOT_W     = 12;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int CFG_DATA_W = 24;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  dest_red;
    logic [7:0]  dest_green;
    logic [7:0]  dest_blue;
  } pixel_t;

  typedef struct packed {
    logic       covered;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } result_t;

  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_RADIUS = 3'd4,
    REG_COLOR  = 3'd5,
    REG_ALPHA  = 3'd6
  } reg_index_t;

  // Register view shared by the stages; radius is already limited to half
  // of the smaller side.
  typedef struct packed {
    logic signed [12:0] left;
    logic signed [12:0] top;
    logic [12:0]        width;
    logic [12:0]        height;
    logic [11:0]        radius;
    logic [23:0]        fill;
    logic [8:0]         alpha;
  } cfg_t;

  // What an item carries alongside the square root.
  typedef struct packed {
    pos_t        rx;
    logic [23:0] dest;
    logic        in_rect;
    logic        corner;
  } side_t;

endpackage
`default_nettype wire

// ----- design/rrfb_ctl.sv -----
`default_nettype none
module rrfb_ctl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       out_stall,
  output logic                            in_stall,
  output logic [rrfb_pkg::STAGES-1:0]     en,
  output logic [rrfb_pkg::STAGES-1:0]     valid
);
  import rrfb_pkg::*;

  // A stage may load when it is empty or everything after it can move.
  for (genvar k = 0; k < STAGES; k++) begin : g_en
    assign en[k] = !out_stall || !(&valid[STAGES-1:k]);
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= (valid & ~en) | ({valid[STAGES-2:0], in_valid} & en);
    end
  end

endmodule
`default_nettype wire

// ----- design/rrfb_geom.sv -----
`default_nettype none
module rrfb_geom #(
  parameter int SCREEN_WIDTH  = 4096,
  parameter int SCREEN_HEIGHT = 4096
) (
  input  wire logic                            clk,
  input  wire logic [rrfb_pkg::GEOM_STAGES-1:0] en,
  input  wire rrfb_pkg::cfg_t                  cfg,
  input  wire rrfb_pkg::pixel_t                pix,
  output rrfb_pkg::side_t                      side,
  output logic [rrfb_pkg::RAD_W-1:0]           radicand
);
  import rrfb_pkg::*;

  pos_t        rx0_c, ry0_c, rx0, ry0;
  logic        ok0_c, ok0;
  logic [23:0] dest0;

  pos_t        w_s, h_s, r_s, d_top, d_bot;
  logic        inside1_c, top1, bot1;
  side_t       side1_c, side1, side2;
  logic [11:0] d1_c, d1;

  logic [RAD_W-1:0] rr2, dd2;

  // Stage 0: position relative to the rectangle corner and cheap rejects.
  always_comb begin
    rx0_c = pos_t'({3'b000, pix.pixel_x}) - pos_t'({{2{cfg.left[12]}}, cfg.left});
    ry0_c = pos_t'({3'b000, pix.pixel_y}) - pos_t'({{2{cfg.top[12]}}, cfg.top});
    ok0_c = (cfg.width != '0) && (cfg.height != '0) && (cfg.alpha != '0) &&
            (int'(pix.pixel_x) < SCREEN_WIDTH) && (int'(pix.pixel_y) < SCREEN_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rx0   <= rx0_c;
      ry0   <= ry0_c;
      ok0   <= ok0_c;
      dest0 <= {pix.dest_red, pix.dest_green, pix.dest_blue};
    end
  end

  // Stage 1: bounding box test and distance from the corner center row.
  always_comb begin
    w_s       = pos_t'({2'b00, cfg.width});
    h_s       = pos_t'({2'b00, cfg.height});
    r_s       = pos_t'({3'b000, cfg.radius});
    inside1_c = ok0 && (rx0 >= 15'sd0) && (rx0 < w_s) && (ry0 >= 15'sd0) && (ry0 < h_s);
    top1      = ry0 < r_s;
    bot1      = ry0 >= (h_s - r_s);
    d_top     = r_s - ry0;
    d_bot     = r_s - (h_s - 15'sd1 - ry0);
    d1_c      = top1 ? d_top[11:0] : d_bot[11:0];
    side1_c.rx      = rx0;
    side1_c.dest    = dest0;
    side1_c.in_rect = inside1_c;
    side1_c.corner  = inside1_c && (cfg.radius != '0) && (top1 || bot1);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side1 <= side1_c;
      d1    <= d1_c;
    end
  end

  // Stage 2: squares of radius and row distance.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      side2 <= side1;
      rr2   <= RAD_W'(cfg.radius) * RAD_W'(cfg.radius);
      dd2   <= RAD_W'(d1) * RAD_W'(d1);
    end
  end

  // Stage 3: radicand of the half span.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      side     <= side2;
      radicand <= rr2 - dd2;
    end
  end

endmodule
`default_nettype wire

// ----- design/rrfb_sqrt.sv -----
`default_nettype none
module rrfb_sqrt (
  input  wire logic                             clk,
  input  wire logic [rrfb_pkg::SQRT_STAGES-1:0] en,
  input  wire rrfb_pkg::side_t                  side_in,
  input  wire logic [rrfb_pkg::RAD_W-1:0]       radicand,
  output rrfb_pkg::side_t                       side_out,
  output logic [rrfb_pkg::ROOT_W-1:0]           root
);
  import rrfb_pkg::*;

  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] q;
  } sq_t;

  // One restoring digit: try setting root bit i against the remainder.
  function automatic sq_t sq_step(sq_t cur, int i);
    logic [RAD_W:0] trial;
    sq_t            nxt;
    trial = ((RAD_W+1)'(cur.q) << (i + 1)) + ((RAD_W+1)'(1) << (2 * i));
    nxt   = cur;
    if ({1'b0, cur.rem} >= trial) begin
      nxt.rem = cur.rem - trial[RAD_W-1:0];
      nxt.q   = cur.q | (ROOT_W'(1) << i);
    end
    return nxt;
  endfunction

  sq_t   sq     [SQRT_STAGES+1];
  side_t side_s [SQRT_STAGES+1];

  assign sq[0]     = '{rem: radicand, q: '0};
  assign side_s[0] = side_in;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    sq_t   lo_c, hi_c, sq_r;
    side_t side_r;

    always_comb begin
      hi_c = sq_step(sq[j], ROOT_W - 1 - 2 * j);
      lo_c = sq_step(hi_c, ROOT_W - 2 - 2 * j);
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        sq_r   <= lo_c;
        side_r <= side_s[j];
      end
    end

    assign sq[j+1]     = sq_r;
    assign side_s[j+1] = side_r;
  end

  assign root     = sq[SQRT_STAGES].q;
  assign side_out = side_s[SQRT_STAGES];

endmodule
`default_nettype wire

// ----- design/rrfb_blend.sv -----
`default_nettype none
module rrfb_blend (
  input  wire logic                              clk,
  input  wire logic [rrfb_pkg::BLEND_STAGES-1:0] en,
  input  wire rrfb_pkg::cfg_t                    cfg,
  input  wire rrfb_pkg::side_t                   side,
  input  wire logic [rrfb_pkg::ROOT_W-1:0]       root,
  output rrfb_pkg::result_t                      res
);
  import rrfb_pkg::*;

  pos_t        r_s, w_s, s_s, span_from, span_to;
  logic        cov_c, cov;
  logic [8:0]  inv_alpha;
  logic [23:0] dest;
  logic [16:0] pd_c [3];
  logic [16:0] pc_c [3];
  logic [16:0] pd   [3];
  logic [16:0] pc   [3];
  logic [16:0] sum  [3];
  logic [23:0] mix;
  logic [23:0] color;

  // Stage A: row span test and the blend products.
  always_comb begin
    r_s       = pos_t'({3'b000, cfg.radius});
    w_s       = pos_t'({2'b00, cfg.width});
    s_s       = pos_t'({3'b000, root});
    span_from = r_s - s_s;
    span_to   = w_s - r_s + s_s;
    cov_c     = side.in_rect &&
                (!side.corner || ((side.rx >= span_from) && (side.rx < span_to)));
    inv_alpha = 9'd256 - cfg.alpha;
    for (int c = 0; c < 3; c++) begin
      pd_c[c] = 17'(side.dest[8*c +: 8]) * 17'(inv_alpha);
      pc_c[c] = 17'(cfg.fill[8*c +: 8]) * 17'(cfg.alpha);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cov  <= cov_c;
      dest <= side.dest;
      pd   <= pd_c;
      pc   <= pc_c;
    end
  end

  // Stage B: sum, scale and choose the outgoing color.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c]         = pd[c] + pc[c];
      mix[8*c +: 8]  = sum[c][15:8];
    end
    if (!cov) begin
      color = dest;
    end else if (cfg.alpha >= 9'd255) begin
      color = cfg.fill;
    end else begin
      color = mix;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      res <= result_t'({cov, color});
    end
  end

endmodule
`default_nettype wire

// ----- design/rounded_rect_fill_blend.sv -----
// Throughput: one pixel per cycle; the twelve stages each hold one item and
// close up bubbles, so pix_stall rises only when every stage is full and
// res_stall is high. The square root takes six of the stages, two digits each.
// Reset (rst, synchronous) empties the pipeline and sets the registers to zero,
// except alpha_level, which becomes 256.
`default_nettype none
module rounded_rect_fill_blend #(
  parameter int SCREEN_WIDTH  = 4096,
  parameter int SCREEN_HEIGHT = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            pix_valid,
  output logic                                 pix_stall,
  input  wire rrfb_pkg::pixel_t                pix,
  output logic                                 res_valid,
  input  wire logic                            res_stall,
  output rrfb_pkg::result_t                    res,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [2:0]                      cfg_index,
  input  wire logic [rrfb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rrfb_pkg::*;

  logic signed [12:0] rect_left, rect_top;
  logic [12:0]        rect_width, rect_height, short_side;
  logic [11:0]        corner_radius, half_side;
  logic [23:0]        fill_color;
  logic [8:0]         alpha_level;
  cfg_t               cfg;

  logic [STAGES-1:0]  stage_en, stage_valid;
  side_t              side_geom, side_root;
  logic [RAD_W-1:0]   radicand;
  logic [ROOT_W-1:0]  root;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left     <= '0;
      rect_top      <= '0;
      rect_width    <= '0;
      rect_height   <= '0;
      corner_radius <= '0;
      fill_color    <= '0;
      alpha_level   <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT:   rect_left     <= cfg_data[12:0];
        REG_TOP:    rect_top      <= cfg_data[12:0];
        REG_WIDTH:  rect_width    <= cfg_data[12:0];
        REG_HEIGHT: rect_height   <= cfg_data[12:0];
        REG_RADIUS: corner_radius <= cfg_data[11:0];
        REG_COLOR:  fill_color    <= cfg_data[23:0];
        REG_ALPHA:  alpha_level   <= cfg_data[8:0];
        default:    ;
      endcase
    end
  end

  // The radius never exceeds half of the smaller side.
  always_comb begin
    short_side = (rect_width < rect_height) ? rect_width : rect_height;
    half_side  = short_side[12:1];
    cfg.left   = rect_left;
    cfg.top    = rect_top;
    cfg.width  = rect_width;
    cfg.height = rect_height;
    cfg.radius = (corner_radius < half_side) ? corner_radius : half_side;
    cfg.fill   = fill_color;
    cfg.alpha  = alpha_level;
  end

  rrfb_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_valid),
    .out_stall (res_stall),
    .in_stall  (pix_stall),
    .en        (stage_en),
    .valid     (stage_valid)
  );

  rrfb_geom #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_geom (
    .clk      (clk),
    .en       (stage_en[GEOM_STAGES-1:0]),
    .cfg      (cfg),
    .pix      (pix),
    .side     (side_geom),
    .radicand (radicand)
  );

  rrfb_sqrt u_sqrt (
    .clk      (clk),
    .en       (stage_en[GEOM_STAGES +: SQRT_STAGES]),
    .side_in  (side_geom),
    .radicand (radicand),
    .side_out (side_root),
    .root     (root)
  );

  rrfb_blend u_blend (
    .clk  (clk),
    .en   (stage_en[STAGES-1 -: BLEND_STAGES]),
    .cfg  (cfg),
    .side (side_root),
    .root (root),
    .res  (res)
  );

  assign res_valid = stage_valid[STAGES-1];

  // The input is held back only when the whole pipeline is full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (&stage_valid))
    else $error("input stalled with a free pipeline stage");

  a_empty_rect: assert property (@(posedge clk) disable iff (rst)
    res_valid && ((rect_width == '0) || (rect_height == '0) || (alpha_level == '0))
      |-> !res.covered)
    else $error("empty rectangle or zero alpha covered a pixel");

  a_opaque: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.covered && (alpha_level >= 9'd255)
      |-> ({res.out_red, res.out_green, res.out_blue} == fill_color))
    else $error("opaque fill did not write the fill color");

  a_no_stall_flow: assert property (@(posedge clk) disable iff (rst)
    !res_stall && !pix_valid |=> !stage_valid[0])
    else $error("first stage kept an item after the pipeline advanced");

endmodule
`default_nettype wire
